[hw/rtl/fixed_block_pool_allocator_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the block pool allocator
// Shared property wrappers; every property is clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define FBPA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define FBPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/fbpa_pkg.sv]
// ----------------------------------------------------------------------------
// fbpa_pkg
// Types, widths and codes shared by the block pool allocator modules.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    // default pool depth and pointer size in bytes (a power of two)
    localparam int MAX_BLOCKS_DEF = 256;
    localparam int PTR_BYTES      = 4;

    // fixed field widths
    localparam int ADDR_W    = 32;
    localparam int REQ_W     = 16;
    localparam int CNT_IN_W  = 9;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;
    // rounded block size: up to 65536 (65535 rounded up to PTR_BYTES)
    localparam int SIZE_W    = 17;

    // item opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STRICT = 8'd3;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_FOREIGN = 3'd2,
        ST_DOUBLE  = 3'd3,
        ST_NULL    = 3'd4
    } t_status;

    // divider result bundle
    typedef struct packed {
        logic              done;
        logic [ADDR_W-1:0] quo;
        logic [SIZE_W-1:0] rem;
    } t_div_res;

endpackage

[hw/rtl/fbpa_ram.sv]
// ----------------------------------------------------------------------------
// fbpa_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/fbpa_div.sv]
// ----------------------------------------------------------------------------
// fbpa_div
// Restoring divider, one quotient bit per cycle, 32-bit dividend.
// ----------------------------------------------------------------------------
module fbpa_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [fbpa_pkg::ADDR_W-1:0]   i_dividend,
    input  logic [fbpa_pkg::SIZE_W-1:0]   i_divisor,
    output fbpa_pkg::t_div_res            o_res
);
    import fbpa_pkg::*;

    localparam int CNT_W = $clog2(ADDR_W);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [ADDR_W-1:0] r_quo, n_quo;
    logic [SIZE_W-1:0] r_rem, n_rem;
    logic [SIZE_W-1:0] r_div, n_div;
    logic [SIZE_W:0]   shifted;
    logic [SIZE_W:0]   diff;

    // one restoring step per cycle
    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_div   = r_div;
        shifted = {r_rem, r_quo[ADDR_W-1]};
        diff    = shifted - {1'b0, r_div};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            if (shifted >= {1'b0, r_div}) begin
                n_rem = diff[SIZE_W-1:0];
                n_quo = {r_quo[ADDR_W-2:0], 1'b1};
            end else begin
                n_rem = shifted[SIZE_W-1:0];
                n_quo = {r_quo[ADDR_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(ADDR_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_res.done = r_done;
    assign o_res.quo  = r_quo;
    assign o_res.rem  = r_rem;

endmodule

[hw/rtl/fixed_block_pool_allocator.sv]
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Fixed-size block pool with a LIFO free list, free checks and usage counts.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result shows on
// the o_ ports for exactly one cycle with o_strobe high, and the receiver
// cannot stall it. An allocate steps through free-list read (empty if the
// popped index is outside the pool), multiply, add and result when the free
// list has an entry, through multiply, add and result when served from
// untouched blocks, and reports at once when the pool is empty. A free of
// null or of an address below the base reports at once; any other free runs
// the offset through the bit-serial divider and then reads the free-mark
// memory, or reports from the divider result when the offset is off the
// block grid, past the pool or on a block never handed out. busy is low in
// the strobe cycle, so the next item can be taken there. Register writes are
// taken only while idle with start low and take effect in the cycle after;
// an untouched-block counter means no clearing pass follows reset or rebuild.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // item channel
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_opcode,
    input  logic [fbpa_pkg::ADDR_W-1:0]       i_address,
    // configuration channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [fbpa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [fbpa_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    // result channel
    output logic                              o_strobe,
    output logic [fbpa_pkg::ADDR_W-1:0]       o_block_address,
    output logic [fbpa_pkg::STATUS_W-1:0]     o_status,
    output logic                              o_fatal,
    output logic [fbpa_pkg::CNT_IN_W-1:0]     o_blocks_in_use,
    output logic [fbpa_pkg::CNT_IN_W-1:0]     o_peak_in_use
);
    import fbpa_pkg::*;

    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int PW = IW + SIZE_W;
    localparam int SREQ_RST   = (4 < PTR_BYTES) ? PTR_BYTES : 4;
    localparam int SIZE_RST   = ((SREQ_RST + PTR_BYTES - 1) / PTR_BYTES) * PTR_BYTES;
    localparam int N_RST      = (256 < MAX_BLOCKS) ? 256 : MAX_BLOCKS;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_A_RD  = 6'b000010,
        S_A_MUL = 6'b000100,
        S_A_ADD = 6'b001000,
        S_F_DIV = 6'b010000,
        S_F_RD  = 6'b100000
    } t_state;

    // control state
    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_base, n_base;
    logic [SIZE_W-1:0] r_size, n_size;
    logic [CW-1:0]     r_n, n_n;
    logic              r_strict, n_strict;
    logic [CW-1:0]     r_stack_cnt, n_stack_cnt;
    logic [CW-1:0]     r_untouched, n_untouched;
    logic [CW-1:0]     r_in_use, n_in_use;
    logic [CW-1:0]     r_peak, n_peak;
    logic              r_strobe, n_strobe;

    // payload
    logic [IW-1:0]     r_idx, n_idx;
    logic [PW-1:0]     r_prod, n_prod;
    logic [ADDR_W-1:0] r_out_addr, n_out_addr;
    t_status           r_out_status, n_out_status;
    logic              r_out_fatal, n_out_fatal;

    // memory and divider ports
    logic              stk_we, stk_re;
    logic [IW-1:0]     stk_waddr, stk_raddr, stk_wdata, stk_rdata;
    logic              mk_we, mk_re, mk_wdata, mk_rdata;
    logic [IW-1:0]     mk_waddr, mk_raddr;
    logic              div_start;
    logic [ADDR_W-1:0] div_dividend;
    logic [SIZE_W-1:0] div_divisor;
    t_div_res          div_res;

    // helpers
    logic              cfg_we, accept;
    logic [CW-1:0]     stk_cnt_m1, inc_in_use;
    logic [SIZE_W-1:0] sreq;
    logic [IW-1:0]     q_idx;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !start;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign accept      = start && !busy;
    assign stk_cnt_m1  = r_stack_cnt - 1'b1;
    assign inc_in_use  = r_in_use + 1'b1;
    assign q_idx       = div_res.quo[IW-1:0];

    // requested size raised to the pointer size
    assign sreq = (32'(i_cfg_data[REQ_W-1:0]) < 32'(PTR_BYTES)) ?
                  SIZE_W'(PTR_BYTES) : SIZE_W'(i_cfg_data[REQ_W-1:0]);

    // freed-block stack and free marks
    fbpa_ram #(.WIDTH(IW), .DEPTH(MAX_BLOCKS)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    fbpa_ram #(.WIDTH(1), .DEPTH(MAX_BLOCKS)) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (mk_we),
        .i_waddr (mk_waddr),
        .i_wdata (mk_wdata),
        .i_re    (mk_re),
        .i_raddr (mk_raddr),
        .o_rdata (mk_rdata)
    );

    // offset-to-index divider
    fbpa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_res      (div_res)
    );

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_base       = r_base;
        n_size       = r_size;
        n_n          = r_n;
        n_strict     = r_strict;
        n_stack_cnt  = r_stack_cnt;
        n_untouched  = r_untouched;
        n_in_use     = r_in_use;
        n_peak       = r_peak;
        n_strobe     = 1'b0;
        n_idx        = r_idx;
        n_prod       = r_prod;
        n_out_addr   = r_out_addr;
        n_out_status = r_out_status;
        n_out_fatal  = r_out_fatal;
        stk_we       = 1'b0;
        stk_waddr    = r_stack_cnt[IW-1:0];
        stk_wdata    = r_idx;
        stk_re       = 1'b0;
        stk_raddr    = stk_cnt_m1[IW-1:0];
        mk_we        = 1'b0;
        mk_waddr     = r_idx;
        mk_wdata     = 1'b0;
        mk_re        = 1'b0;
        mk_raddr     = q_idx;
        div_start    = 1'b0;
        div_dividend = i_address - r_base;
        div_divisor  = r_size;

        case (r_state)
            S_IDLE: begin
                if (cfg_we) begin
                    // pool rebuild for geometry writes
                    if (i_cfg_index == REG_BASE || i_cfg_index == REG_SIZE ||
                        i_cfg_index == REG_COUNT) begin
                        n_stack_cnt = '0;
                        n_untouched = '0;
                        n_in_use    = '0;
                        n_peak      = '0;
                    end
                    if (i_cfg_index == REG_BASE) begin
                        n_base = i_cfg_data;
                    end else if (i_cfg_index == REG_SIZE) begin
                        // round up to a whole number of pointers
                        n_size = (sreq + SIZE_W'(PTR_BYTES - 1)) &
                                 ~SIZE_W'(PTR_BYTES - 1);
                    end else if (i_cfg_index == REG_COUNT) begin
                        if (32'(i_cfg_data[CNT_IN_W-1:0]) > 32'(MAX_BLOCKS)) begin
                            n_n = CW'(MAX_BLOCKS);
                        end else begin
                            n_n = CW'(i_cfg_data[CNT_IN_W-1:0]);
                        end
                    end else if (i_cfg_index == REG_STRICT) begin
                        n_strict = i_cfg_data[0];
                    end
                end else if (accept) begin
                    n_out_addr  = '0;
                    n_out_fatal = 1'b0;
                    if (i_opcode == OP_ALLOC) begin
                        // allocate: freed blocks first, then untouched ones
                        if (r_stack_cnt != '0) begin
                            n_stack_cnt = stk_cnt_m1;
                            stk_re      = 1'b1;
                            n_state     = S_A_RD;
                        end else if (r_untouched < r_n) begin
                            n_idx       = r_untouched[IW-1:0];
                            n_untouched = r_untouched + 1'b1;
                            n_state     = S_A_MUL;
                        end else begin
                            n_out_status = ST_EMPTY;
                            n_strobe     = 1'b1;
                        end
                    end else if (i_address == '0) begin
                        n_out_status = ST_NULL;
                        n_strobe     = 1'b1;
                    end else if (i_address < r_base) begin
                        n_out_status = ST_FOREIGN;
                        n_out_fatal  = r_strict;
                        n_strobe     = 1'b1;
                    end else begin
                        div_start = 1'b1;
                        n_state   = S_F_DIV;
                    end
                end
            end

            S_A_RD: begin
                // popped index is valid only inside the pool
                if (CW'(stk_rdata) < r_n) begin
                    n_idx   = stk_rdata;
                    n_state = S_A_MUL;
                end else begin
                    n_out_status = ST_EMPTY;
                    n_strobe     = 1'b1;
                    n_state      = S_IDLE;
                end
            end

            S_A_MUL: begin
                n_prod   = PW'(r_idx) * PW'(r_size);
                mk_we    = 1'b1;
                mk_wdata = 1'b0;
                n_in_use = inc_in_use;
                if (inc_in_use > r_peak) begin
                    n_peak = inc_in_use;
                end
                n_state = S_A_ADD;
            end

            S_A_ADD: begin
                n_out_addr   = r_base + ADDR_W'(r_prod);
                n_out_status = ST_OK;
                n_strobe     = 1'b1;
                n_state      = S_IDLE;
            end

            S_F_DIV: begin
                if (div_res.done) begin
                    if (div_res.rem != '0 || div_res.quo >= ADDR_W'(r_n)) begin
                        n_out_status = ST_FOREIGN;
                        n_out_fatal  = r_strict;
                        n_strobe     = 1'b1;
                        n_state      = S_IDLE;
                    end else if (CW'(q_idx) >= r_untouched) begin
                        // never handed out: still free
                        n_out_status = ST_DOUBLE;
                        n_out_fatal  = r_strict;
                        n_strobe     = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        mk_re   = 1'b1;
                        n_idx   = q_idx;
                        n_state = S_F_RD;
                    end
                end
            end

            S_F_RD: begin
                if (mk_rdata) begin
                    n_out_status = ST_DOUBLE;
                    n_out_fatal  = r_strict;
                end else begin
                    if (r_stack_cnt < CW'(MAX_BLOCKS)) begin
                        stk_we      = 1'b1;
                        mk_we       = 1'b1;
                        mk_wdata    = 1'b1;
                        n_stack_cnt = r_stack_cnt + 1'b1;
                        if (r_in_use != '0) begin
                            n_in_use = r_in_use - 1'b1;
                        end
                    end
                    n_out_status = ST_OK;
                end
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= '0;
            r_size      <= SIZE_W'(SIZE_RST);
            r_n         <= CW'(N_RST);
            r_strict    <= 1'b0;
            r_stack_cnt <= '0;
            r_untouched <= '0;
            r_in_use    <= '0;
            r_peak      <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_size      <= n_size;
            r_n         <= n_n;
            r_strict    <= n_strict;
            r_stack_cnt <= n_stack_cnt;
            r_untouched <= n_untouched;
            r_in_use    <= n_in_use;
            r_peak      <= n_peak;
            r_strobe    <= n_strobe;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_prod       <= n_prod;
        r_out_addr   <= n_out_addr;
        r_out_status <= n_out_status;
        r_out_fatal  <= n_out_fatal;
    end

    assign o_strobe        = r_strobe;
    assign o_block_address = r_out_addr;
    assign o_status        = r_out_status;
    assign o_fatal         = r_out_fatal;
    assign o_blocks_in_use = CNT_IN_W'(r_in_use);
    assign o_peak_in_use   = CNT_IN_W'(r_peak);

endmodule

[hw/rtl/fbpa_chk.sv]
// ----------------------------------------------------------------------------
// fbpa_chk
// Port-level checks for the block pool allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "fixed_block_pool_allocator_assert.svh"

module fbpa_chk (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic                              o_strobe,
    input  logic [fbpa_pkg::ADDR_W-1:0]       o_block_address,
    input  logic [fbpa_pkg::STATUS_W-1:0]     o_status,
    input  logic                              o_fatal
);
    import fbpa_pkg::*;

    // an accepted item either starts work or reports at once
    `FBPA_ASSERT_NEXT(a_accept_progress, i_clk, i_rst_n, start && !busy, busy || o_strobe, "accepted item neither started nor reported")

    // results are reported only once the sequencer is back to idle
    `FBPA_ASSERT_SAME(a_strobe_idle, i_clk, i_rst_n, o_strobe, !busy, "result strobe while busy")

    // fatal only on a rejected free
    `FBPA_ASSERT_SAME(a_fatal_reject, i_clk, i_rst_n, o_strobe && o_fatal, o_status == ST_FOREIGN || o_status == ST_DOUBLE, "fatal without rejected free")

    // a nonzero address is only handed out on success
    `FBPA_ASSERT_SAME(a_addr_ok, i_clk, i_rst_n, o_strobe && (o_block_address != '0), o_status == ST_OK, "address with failing status")

endmodule

bind fixed_block_pool_allocator fbpa_chk u_fbpa_chk (.*);
